[rtl/kmh_pkg.sv]
// Shared types, codes and helpers for the k-mer histogram unit.
package kmh_pkg;

  // Input opcodes; code 3 carries no meaning and is dropped.
  typedef enum logic [1:0] {
    OP_CHAR     = 2'd0,
    OP_READ     = 2'd1,
    OP_READ_SET = 2'd2
  } opcode_e;

  // Commands queued from the front end to the counter back end.
  typedef enum logic [1:0] {
    CMD_BUMP     = 2'd0,
    CMD_READ     = 2'd1,
    CMD_READ_SET = 2'd2
  } cmd_op_e;

  localparam int CMD_OP_BITS = 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OVERLAP_MODE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PSEUDOCOUNT  = 2'd2;

  localparam logic [3:0]  WORD_LENGTH_RST  = 4'd4;
  localparam logic        OVERLAP_MODE_RST = 1'b1;
  localparam logic [15:0] PSEUDOCOUNT_RST  = 16'd0;

  // Field widths fixed by the interface.
  localparam int BIN_INDEX_BITS = 16;
  localparam int BIN_COUNT_BITS = 32;
  localparam int RESULT_BITS    = BIN_COUNT_BITS + BIN_INDEX_BITS;

  // Nucleotide characters.
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_C = 8'h43;
  localparam logic [7:0] CH_UP_G = 8'h47;
  localparam logic [7:0] CH_UP_T = 8'h54;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_C = 8'h63;
  localparam logic [7:0] CH_LO_G = 8'h67;
  localparam logic [7:0] CH_LO_T = 8'h74;

  typedef struct packed {
    logic [3:0]  word_length;
    logic        overlap_mode;
    logic [15:0] pseudocount;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } nt_t;

  // Map a sequence byte to its 2-bit code; anything else is not a base.
  function automatic nt_t nt_decode(input logic [7:0] ch);
    nt_t r;
    r.valid = 1'b1;
    r.code  = 2'd0;
    case (ch)
      CH_UP_A, CH_LO_A: r.code = 2'd0;
      CH_UP_C, CH_LO_C: r.code = 2'd1;
      CH_UP_G, CH_LO_G: r.code = 2'd2;
      CH_UP_T, CH_LO_T: r.code = 2'd3;
      default:          r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/dna_kmer_histogram_unit.sv]
// Top level of the k-mer histogram unit: configuration, front end, queues, back end.
//
// The unit counts k-mers of a nucleotide stream in a store of 4^MAX_WORD
// saturating counters of COUNT_BITS bits. After reset the store is swept to
// zero, one bin per cycle, so in_ready_o stays low until every bin is cleared;
// configuration writes are taken during that sweep. After it, one input word
// is taken every cycle while the command queue has room: the front end updates
// the rolling index and run trackers in the cycle a character is accepted and
// queues at most one command per word, and the back end retires one command
// per cycle, unless a read waits for room, as a read-modify-write on the
// single-write, registered-read counter RAM, with a one-deep bypass for
// back-to-back hits on the same bin. A read passes through the command queue
// and the back-end stage before its result is pushed into the four-word result
// queue, where it waits at out_valid_o. Once a stalled consumer has that queue
// committed, a read at the head of the command queue waits for room, every
// command behind it waits too, and the input stalls as soon as the two-entry
// command queue fills. Write the configuration only while no words are in flight.
module dna_kmer_histogram_unit #(
  parameter int MAX_WORD   = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [kmh_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [kmh_pkg::CFG_DATA_BITS-1:0]     cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            opcode_i,
  input  logic [7:0]                            char_code_i,
  input  logic                                  last_of_sequence_i,
  input  logic [kmh_pkg::BIN_INDEX_BITS-1:0]    bin_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [kmh_pkg::BIN_COUNT_BITS-1:0]    bin_count_o,
  output logic [kmh_pkg::BIN_INDEX_BITS-1:0]    bin_echo_o
);

  localparam int INDEX_BITS = 2 * MAX_WORD;
  localparam int CMD_W      = kmh_pkg::CMD_OP_BITS + INDEX_BITS;
  localparam int CMD_DEPTH  = 2;
  localparam int OUT_DEPTH  = 4;
  localparam int OCW        = $clog2(OUT_DEPTH + 1);

  kmh_pkg::cfg_t         cfg_q;
  kmh_pkg::back_status_t back_status;

  logic                  cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic [CMD_W-1:0]      cmd_wdata, cmd_rdata;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  logic                  res_push, res_empty, res_full;
  logic [kmh_pkg::RESULT_BITS-1:0] res_wdata, res_rdata;
  logic [OCW-1:0]        res_count;

  // Configuration registers; unknown indexes drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.word_length  <= kmh_pkg::WORD_LENGTH_RST;
      cfg_q.overlap_mode <= kmh_pkg::OVERLAP_MODE_RST;
      cfg_q.pseudocount  <= kmh_pkg::PSEUDOCOUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kmh_pkg::REG_WORD_LENGTH:  cfg_q.word_length  <= cfg_wdata_i[3:0];
        kmh_pkg::REG_OVERLAP_MODE: cfg_q.overlap_mode <= cfg_wdata_i[0];
        kmh_pkg::REG_PSEUDOCOUNT:  cfg_q.pseudocount  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Front end: classify words and advance the k-mer trackers.
  kmh_front #(
    .MAX_WORD   (MAX_WORD),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .status_i           (back_status),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .char_code_i        (char_code_i),
    .last_of_sequence_i (last_of_sequence_i),
    .bin_index_i        (bin_index_i),
    .cmd_full_i         (cmd_full),
    .cmd_push_o         (cmd_push),
    .cmd_o              (cmd_wdata)
  );

  // Command queue decouples the trackers from the counter pipeline.
  kmh_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  // Back end: bin store with read-modify-write pipeline.
  kmh_back #(
    .INDEX_BITS (INDEX_BITS),
    .COUNT_BITS (COUNT_BITS),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pseudocount_i (cfg_q.pseudocount),
    .status_o      (back_status),
    .cmd_valid_i   (!cmd_empty && (cmd_count != '0)),
    .cmd_i         (cmd_rdata),
    .cmd_pop_o     (cmd_pop),
    .res_count_i   (res_count),
    .res_push_o    (res_push),
    .res_data_o    (res_wdata)
  );

  // Result queue; the back end never pushes without reserved room.
  kmh_fifo #(
    .WIDTH (kmh_pkg::RESULT_BITS),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push && !res_full),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (out_valid_o && out_ready_i),
    .rdata_o (res_rdata),
    .empty_o (res_empty),
    .count_o (res_count)
  );

  assign out_valid_o = !res_empty;
  assign bin_count_o = res_rdata[kmh_pkg::RESULT_BITS-1 -: kmh_pkg::BIN_COUNT_BITS];
  assign bin_echo_o  = res_rdata[kmh_pkg::BIN_INDEX_BITS-1:0];

endmodule

[rtl/kmh_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module kmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old content on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kmh_fifo.sv]
// Small register FIFO used for the command queue and the result queue.
module kmh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    count_q, count_d;

  always_comb begin
    wr_d    = push_i ? wr_q + 1'b1 : wr_q;
    rd_d    = pop_i ? rd_q + 1'b1 : rd_q;
    count_d = count_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;

endmodule

[rtl/kmh_front.sv]
// Front end: accepts words, tracks the rolling k-mer and emits bin commands.
module kmh_front #(
  parameter int MAX_WORD   = 8,
  parameter int INDEX_BITS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  kmh_pkg::cfg_t                             cfg_i,
  input  kmh_pkg::back_status_t                     status_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [1:0]                                opcode_i,
  input  logic [7:0]                                char_code_i,
  input  logic                                      last_of_sequence_i,
  input  logic [kmh_pkg::BIN_INDEX_BITS-1:0]        bin_index_i,
  input  logic                                      cmd_full_i,
  output logic                                      cmd_push_o,
  output logic [kmh_pkg::CMD_OP_BITS+INDEX_BITS-1:0] cmd_o
);

  localparam int KW = $clog2(MAX_WORD + 1);
  localparam int PW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  logic [INDEX_BITS-1:0] roll_q, roll_d;
  logic [KW-1:0]         run_q, run_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic                  blk_ok_q, blk_ok_d;

  logic [3:0]            k_raw;
  logic [KW-1:0]         k_eff;
  logic [INDEX_BITS-1:0] kmask;
  logic [KW:0]           run_inc, pos_inc;
  logic                  blk_done, blk_ok_mid, bump;
  kmh_pkg::nt_t          nt;
  logic [INDEX_BITS-1:0] kmer_ix;
  logic [31:0]           ix_wide;
  logic [INDEX_BITS-1:0] ix;
  logic                  accept, need_cmd;
  kmh_pkg::cmd_op_e      cmd_op;
  logic [INDEX_BITS-1:0] cmd_ix;

  // Clamp K into 1..MAX_WORD.
  always_comb begin
    if (cfg_i.word_length == 4'd0) begin
      k_raw = 4'd1;
    end else if (cfg_i.word_length > 4'(MAX_WORD)) begin
      k_raw = 4'(MAX_WORD);
    end else begin
      k_raw = cfg_i.word_length;
    end
    k_eff = KW'(k_raw);
  end

  always_comb begin
    kmask = '0;
    for (int i = 0; i < MAX_WORD; i++) begin
      kmask[2*i +: 2] = (i < int'(k_eff)) ? 2'b11 : 2'b00;
    end
  end

  // Tracker update for one character.
  always_comb begin
    nt         = kmh_pkg::nt_decode(char_code_i);
    run_inc    = (KW+1)'(run_q) + 1'b1;
    pos_inc    = (KW+1)'(pos_q) + 1'b1;
    blk_done   = (pos_inc >= (KW+1)'(k_eff));
    roll_d     = roll_q;
    run_d      = run_q;
    blk_ok_mid = blk_ok_q;
    if (nt.valid) begin
      roll_d = ((roll_q << 2) | INDEX_BITS'(nt.code)) & kmask;
      run_d  = (run_inc < (KW+1)'(k_eff)) ? run_inc[KW-1:0] : k_eff;
    end else begin
      run_d      = '0;
      blk_ok_mid = 1'b0;
    end
    if (cfg_i.overlap_mode) begin
      bump = nt.valid && (run_d >= k_eff);
    end else begin
      bump = blk_done && blk_ok_mid;
    end
    // Bump the window this character closes, ahead of any end-of-sequence clear.
    kmer_ix = roll_d;
    if (blk_done) begin
      pos_d    = '0;
      blk_ok_d = 1'b1;
    end else begin
      pos_d    = pos_inc[PW-1:0];
      blk_ok_d = blk_ok_mid;
    end
    if (last_of_sequence_i) begin
      roll_d   = '0;
      run_d    = '0;
      pos_d    = '0;
      blk_ok_d = 1'b1;
    end
  end

  assign ix_wide    = 32'(bin_index_i);
  assign ix         = ix_wide[INDEX_BITS-1:0];
  assign in_ready_o = !status_i.clearing && !cmd_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the word into a back-end command, if any.
  always_comb begin
    need_cmd = 1'b0;
    cmd_op   = kmh_pkg::CMD_BUMP;
    cmd_ix   = kmer_ix;
    case (kmh_pkg::opcode_e'(opcode_i))
      kmh_pkg::OP_CHAR: begin
        need_cmd = bump;
      end
      kmh_pkg::OP_READ: begin
        need_cmd = 1'b1;
        cmd_op   = kmh_pkg::CMD_READ;
        cmd_ix   = ix;
      end
      kmh_pkg::OP_READ_SET: begin
        need_cmd = 1'b1;
        cmd_op   = kmh_pkg::CMD_READ_SET;
        cmd_ix   = ix;
      end
      default: begin
        need_cmd = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = accept && need_cmd;
  assign cmd_o      = {cmd_op, cmd_ix};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q   <= '0;
      run_q    <= '0;
      pos_q    <= '0;
      blk_ok_q <= 1'b1;
    end else if (accept && (kmh_pkg::opcode_e'(opcode_i) == kmh_pkg::OP_CHAR)) begin
      roll_q   <= roll_d;
      run_q    <= run_d;
      pos_q    <= pos_d;
      blk_ok_q <= blk_ok_d;
    end
  end

endmodule

[rtl/kmh_back.sv]
// Back end: clears the bin store, then runs bin read-modify-write commands.
module kmh_back #(
  parameter int INDEX_BITS = 16,
  parameter int COUNT_BITS = 32,
  parameter int OUT_DEPTH  = 4
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [15:0]                                pseudocount_i,
  output kmh_pkg::back_status_t                      status_o,
  input  logic                                       cmd_valid_i,
  input  logic [kmh_pkg::CMD_OP_BITS+INDEX_BITS-1:0] cmd_i,
  output logic                                       cmd_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]             res_count_i,
  output logic                                       res_push_o,
  output logic [kmh_pkg::RESULT_BITS-1:0]            res_data_o
);

  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [63:0] COUNT_MAX_W = 64'(COUNT_MAX);
  localparam logic [63:0] REPORT_MAX_W = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    BACK_CLEAR = 2'b01,
    BACK_RUN   = 2'b10
  } back_state_e;

  back_state_e           state_q, state_d;
  logic [INDEX_BITS-1:0] clr_q, clr_d;

  logic                  b_valid_q;
  kmh_pkg::cmd_op_e      b_op_q;
  logic [INDEX_BITS-1:0] b_ix_q;

  logic                  fwd_valid_q;
  logic [INDEX_BITS-1:0] fwd_ix_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  kmh_pkg::cmd_op_e      head_op;
  logic [INDEX_BITS-1:0] head_ix;
  logic                  b_is_read, credit_ok;
  logic [COUNT_BITS-1:0] rdata, old_cnt, new_cnt, set_val;
  logic [63:0]           pseudo_w, old_w;
  logic [31:0]           ix_w;
  logic [kmh_pkg::BIN_COUNT_BITS-1:0] count_rep;

  logic                  we;
  logic [INDEX_BITS-1:0] waddr;
  logic [COUNT_BITS-1:0] wdata;

  assign head_op = kmh_pkg::cmd_op_e'(cmd_i[kmh_pkg::CMD_OP_BITS+INDEX_BITS-1 -: kmh_pkg::CMD_OP_BITS]);
  assign head_ix = cmd_i[INDEX_BITS-1:0];

  // Reads may issue only while the result queue has room for every read in flight.
  assign b_is_read = b_valid_q && (b_op_q != kmh_pkg::CMD_BUMP);
  assign credit_ok = ((OCW+1)'(res_count_i) + (OCW+1)'(b_is_read)) < (OCW+1)'(OUT_DEPTH);

  assign cmd_pop_o = (state_q == BACK_RUN) && cmd_valid_i &&
                     ((head_op == kmh_pkg::CMD_BUMP) || credit_ok);
  assign status_o.clearing = (state_q == BACK_CLEAR);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      BACK_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = BACK_RUN;
        end
      end
      BACK_RUN: begin
        state_d = BACK_RUN;
      end
      default: begin
        state_d = BACK_CLEAR;
      end
    endcase
  end

  // Take the freshest value when the previous cycle wrote this bin.
  always_comb begin
    old_cnt  = (fwd_valid_q && (fwd_ix_q == b_ix_q)) ? fwd_data_q : rdata;
    pseudo_w = 64'(pseudocount_i);
    set_val  = (pseudo_w > COUNT_MAX_W) ? COUNT_MAX : pseudo_w[COUNT_BITS-1:0];
    unique case (b_op_q)
      kmh_pkg::CMD_BUMP:     new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
      kmh_pkg::CMD_READ_SET: new_cnt = set_val;
      default:               new_cnt = old_cnt;
    endcase
    old_w     = 64'(old_cnt);
    count_rep = (old_w > REPORT_MAX_W) ? '1 : old_w[31:0];
    ix_w      = 32'(b_ix_q);
  end

  always_comb begin
    if (state_q == BACK_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = b_valid_q && (b_op_q != kmh_pkg::CMD_READ);
      waddr = b_ix_q;
      wdata = new_cnt;
    end
  end

  assign res_push_o = b_is_read;
  assign res_data_o = {count_rep, ix_w[kmh_pkg::BIN_INDEX_BITS-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_CLEAR;
      clr_q       <= '0;
      b_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      b_valid_q   <= cmd_pop_o;
      fwd_valid_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      b_op_q <= head_op;
      b_ix_q <= head_ix;
    end
    fwd_ix_q   <= waddr;
    fwd_data_q <= wdata;
  end

  kmh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (2 ** INDEX_BITS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_pop_o),
    .raddr_i (head_ix),
    .rdata_o (rdata)
  );

endmodule

[rtl/kmh_checker.sv]
// Port-level checks for the k-mer histogram unit, bound to the top level.
module kmh_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [1:0]                         opcode_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [kmh_pkg::BIN_COUNT_BITS-1:0] bin_count_o,
  input logic [kmh_pkg::BIN_INDEX_BITS-1:0] bin_echo_o
);

  logic       in_read;
  logic       out_take;
  logic [7:0] pending_q;

  assign in_read  = in_valid_i && in_ready_o &&
                    ((kmh_pkg::opcode_e'(opcode_i) == kmh_pkg::OP_READ) ||
                     (kmh_pkg::opcode_e'(opcode_i) == kmh_pkg::OP_READ_SET));
  assign out_take = out_valid_o && out_ready_i;

  // Reads accepted but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(in_read) - 8'(out_take);
    end
  end

  // A stalled result holds its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_count_o) && $stable(bin_echo_o))
    else $error("result word changed while stalled");

  // No result without an open read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 8'd0)
    else $error("result without a pending read");

  // A lone read is not answered in the cycle after it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_read && (pending_q == 8'd0) |=> !out_valid_o)
    else $error("read answered too early");

  // The bin store sweep holds off input right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("input taken before the bin store was cleared");

endmodule

bind dna_kmer_histogram_unit kmh_checker u_kmh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .opcode_i    (opcode_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .bin_count_o (bin_count_o),
  .bin_echo_o  (bin_echo_o)
);
